// ===== rtl/core/nbs_pkg.sv =====
`default_nettype none

package nbs_pkg;

	// Link phases, in the order the sequencer walks them; no transition enters PH_RENEW.
	typedef enum logic [3:0] {
		PH_OFFLINE  = 4'd0,
		PH_AUTOCONF = 4'd1,
		PH_DHCP6    = 4'd2,
		PH_DHCP4    = 4'd3,
		PH_ARP      = 4'd4,
		PH_TUNNEL   = 4'd5,
		PH_ONLINE   = 4'd6,
		PH_RENEW    = 4'd7,
		PH_PANIC    = 4'd8
	} phase_t;

	// Actions requested from the packet side.
	typedef enum logic [2:0] {
		ACT_NONE   = 3'd0,
		ACT_RSOL   = 3'd1,
		ACT_D6SOL  = 3'd2,
		ACT_D4DISC = 3'd3,
		ACT_ARPQ   = 3'd4
	} action_t;

	// Event codes carried by an input item.
	typedef enum logic [2:0] {
		OP_TICK     = 3'd0,
		OP_INITIATE = 3'd1,
		OP_SUCCESS  = 3'd2,
		OP_RESTART  = 3'd3,
		OP_SHUTDOWN = 3'd4
	} op_t;

	localparam int unsigned V4_BINDINGS_DEF = 4;

	localparam int unsigned RETRY_W = 3;
	localparam int unsigned DELAY_W = 13;

	localparam logic [RETRY_W-1:0] RETRY_BASE  = 3'd3;
	localparam logic [RETRY_W-1:0] RETRY_SHORT = 3'd2;
	localparam logic [RETRY_W-1:0] RETRY_RESET = 3'd1;

	localparam logic [DELAY_W-1:0] DELAY_LONG_MS = 13'd5000;
	localparam logic [DELAY_W-1:0] DELAY_ARP_MS  = 13'd250;
	localparam logic [DELAY_W-1:0] DELAY_SOL_MS  = 13'd1000;
	localparam logic [DELAY_W-1:0] DELAY_NOW_MS  = 13'd0;

endpackage

`default_nettype wire

// ===== rtl/core/network_bootstrap_sequencer.sv =====
`default_nettype none

// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  operation, have_v4_address, have_gateway_mac,
//                                           gateway_binding, have_v6_address
// out       output     out_valid / out_stall action, rearm_timer, stop_timer, delay_ms,
//                                           phase_now, tunnel_enable, tunnel_binding
// cfg       input      cfg_valid / cfg_ready cfg_data (retry_seed)
//
// One item per cycle unless out_stall holds; items pass the input, then the result register.
// The phase update is one pass of logic between the input register and the result register.
// Reset puts the link offline with one retry, the tunnel off and the retry seed at zero.
// A stalled result holds the result register; the input register then holds its item and
// in_stall rises, so no item is lost. The configuration port is always ready.

module network_bootstrap_sequencer #(
	parameter int unsigned V4_BINDINGS = nbs_pkg::V4_BINDINGS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,

	input  wire logic                         cfg_valid,
	output      logic                         cfg_ready,
	input  wire logic [1:0]                   cfg_data,

	input  wire logic                         in_valid,
	output      logic                         in_stall,
	input  wire logic [2:0]                   operation,
	input  wire logic                         have_v4_address,
	input  wire logic                         have_gateway_mac,
	input  wire logic [1:0]                   gateway_binding,
	input  wire logic                         have_v6_address,

	output      logic                         out_valid,
	input  wire logic                         out_stall,
	output      logic [2:0]                   action,
	output      logic                         rearm_timer,
	output      logic                         stop_timer,
	output      logic [nbs_pkg::DELAY_W-1:0]  delay_ms,
	output      logic [3:0]                   phase_now,
	output      logic                         tunnel_enable,
	output      logic [1:0]                   tunnel_binding
);

	// Input register.
	logic                             valid_s1;
	logic [2:0]                       op_s1;
	logic                             v4_s1;
	logic                             gw_mac_s1;
	logic [1:0]                       gw_idx_s1;
	logic                             v6_s1;

	// Result register.
	logic                             valid_s2;
	nbs_pkg::action_t                 action_s2;
	logic                             rearm_s2;
	logic                             stop_s2;
	logic [nbs_pkg::DELAY_W-1:0]      delay_s2;

	// Sequencer state.
	nbs_pkg::phase_t                  phase_q;
	logic [nbs_pkg::RETRY_W-1:0]      retries_q;
	logic                             tunnel_on_q;
	logic [1:0]                       tunnel_index_q;
	logic [1:0]                       retry_seed_q;

	// Next state and result from the item in the input register.
	nbs_pkg::phase_t                  ph_d;
	logic [nbs_pkg::RETRY_W-1:0]      rt_d;
	logic                             ton_d;
	logic [1:0]                       tix_d;
	nbs_pkg::action_t                 act_d;
	logic                             rearm_d;
	logic                             stop_d;
	logic [nbs_pkg::DELAY_W-1:0]      delay_d;

	logic                             gw;
	logic                             s2_free;
	logic                             s1_fire;
	logic                             in_fire;

	// Handshake: the result register frees when empty or taken.
	assign s2_free   = !valid_s2 || !out_stall;
	assign s1_fire   = valid_s1 && s2_free;
	assign in_stall  = valid_s1 && !s2_free;
	assign in_fire   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// A gateway counts only when its binding index is in range.
	assign gw = gw_mac_s1 && (32'(gw_idx_s1) < V4_BINDINGS);

	// Phase update for one item.
	always_comb begin
		logic arp_rule;
		logic tun_rule;
		logic auto_rule;

		ph_d      = phase_q;
		rt_d      = retries_q;
		ton_d     = tunnel_on_q;
		tix_d     = tunnel_index_q;
		act_d     = nbs_pkg::ACT_NONE;
		rearm_d   = 1'b0;
		stop_d    = 1'b0;
		delay_d   = nbs_pkg::DELAY_NOW_MS;
		arp_rule  = 1'b0;
		tun_rule  = 1'b0;
		auto_rule = 1'b0;

		case (op_s1)
			nbs_pkg::OP_TICK: begin
				// Spend a retry, or move on when none are left.
				if (rt_d != '0) begin
					rt_d = rt_d - 3'd1;
				end else begin
					rt_d = nbs_pkg::RETRY_BASE;
					if (ph_d <= nbs_pkg::PH_TUNNEL) begin
						ph_d = nbs_pkg::phase_t'(ph_d + 4'd1);
					end else begin
						ph_d = nbs_pkg::PH_PANIC;
					end
				end

				case (ph_d) inside
					nbs_pkg::PH_DHCP4: begin
						if (!v4_s1) begin
							act_d   = nbs_pkg::ACT_D4DISC;
							rearm_d = 1'b1;
							delay_d = nbs_pkg::DELAY_LONG_MS;
							rt_d    = nbs_pkg::RETRY_SHORT;
						end else begin
							ph_d     = nbs_pkg::PH_ARP;
							rt_d     = nbs_pkg::RETRY_BASE;
							arp_rule = 1'b1;
						end
					end
					nbs_pkg::PH_ARP: begin
						arp_rule = 1'b1;
					end
					nbs_pkg::PH_TUNNEL: begin
						tun_rule = 1'b1;
					end
					nbs_pkg::PH_AUTOCONF: begin
						auto_rule = 1'b1;
					end
					nbs_pkg::PH_DHCP6: begin
						if (!v6_s1) begin
							act_d   = nbs_pkg::ACT_D6SOL;
							rearm_d = 1'b1;
							delay_d = nbs_pkg::DELAY_SOL_MS;
						end
					end
					nbs_pkg::PH_ONLINE, nbs_pkg::PH_RENEW, nbs_pkg::PH_PANIC: begin
						act_d = nbs_pkg::ACT_NONE;
					end
					default: begin
						// Offline and meaningless codes re-arm at once.
						rearm_d = 1'b1;
					end
				endcase

				// ARP: query until a gateway MAC is known.
				if (arp_rule) begin
					if (!gw) begin
						act_d   = nbs_pkg::ACT_ARPQ;
						rearm_d = 1'b1;
						delay_d = nbs_pkg::DELAY_ARP_MS;
					end else begin
						ph_d     = nbs_pkg::PH_TUNNEL;
						rt_d     = nbs_pkg::RETRY_SHORT;
						tun_rule = 1'b1;
					end
				end

				// Tunnel: with no IPv6 address, fall back to DHCPv4 without a gateway, else enable it.
				if (tun_rule) begin
					if (!v6_s1 && !gw) begin
						ph_d    = nbs_pkg::PH_DHCP4;
						rt_d    = nbs_pkg::RETRY_SHORT;
						rearm_d = 1'b1;
						delay_d = nbs_pkg::DELAY_LONG_MS;
					end else begin
						if (!v6_s1) begin
							ton_d = 1'b1;
							tix_d = gw_idx_s1;
						end
						auto_rule = 1'b1;
					end
				end

				// Autoconfiguration: solicit a router until an address exists.
				if (auto_rule && !v6_s1) begin
					act_d   = nbs_pkg::ACT_RSOL;
					rearm_d = 1'b1;
					delay_d = nbs_pkg::DELAY_SOL_MS;
				end
			end
			nbs_pkg::OP_INITIATE: begin
				rt_d    = nbs_pkg::RETRY_BASE + {1'b0, retry_seed_q};
				ph_d    = nbs_pkg::PH_AUTOCONF;
				ton_d   = 1'b0;
				tix_d   = '0;
				rearm_d = 1'b1;
			end
			nbs_pkg::OP_SUCCESS: begin
				ph_d   = nbs_pkg::PH_ONLINE;
				stop_d = 1'b1;
			end
			nbs_pkg::OP_RESTART: begin
				rt_d    = nbs_pkg::RETRY_BASE + {1'b0, retry_seed_q};
				ph_d    = nbs_pkg::PH_AUTOCONF;
				rearm_d = 1'b1;
			end
			nbs_pkg::OP_SHUTDOWN: begin
				rt_d   = nbs_pkg::RETRY_RESET;
				ph_d   = nbs_pkg::PH_OFFLINE;
				ton_d  = 1'b0;
				tix_d  = '0;
				stop_d = 1'b1;
			end
			default: begin
				// Unknown events leave everything as it is.
				act_d = nbs_pkg::ACT_NONE;
			end
		endcase
	end

	// Input register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1     <= operation;
			v4_s1     <= have_v4_address;
			gw_mac_s1 <= have_gateway_mac;
			gw_idx_s1 <= gateway_binding;
			v6_s1     <= have_v6_address;
		end
	end

	// Sequencer state and the retry seed register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= nbs_pkg::PH_OFFLINE;
			retries_q      <= nbs_pkg::RETRY_RESET;
			tunnel_on_q    <= 1'b0;
			tunnel_index_q <= '0;
			retry_seed_q   <= '0;
		end else begin
			if (s1_fire) begin
				phase_q        <= ph_d;
				retries_q      <= rt_d;
				tunnel_on_q    <= ton_d;
				tunnel_index_q <= tix_d;
			end
			if (cfg_valid && cfg_ready) begin
				retry_seed_q <= cfg_data;
			end
		end
	end

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			action_s2 <= act_d;
			rearm_s2  <= rearm_d;
			stop_s2   <= stop_d;
			delay_s2  <= delay_d;
		end
	end

	// The state registers already hold the phase after the item in the result register.
	assign out_valid      = valid_s2;
	assign action         = action_s2;
	assign rearm_timer    = rearm_s2;
	assign stop_timer     = stop_s2;
	assign delay_ms       = delay_s2;
	assign phase_now      = phase_q;
	assign tunnel_enable  = tunnel_on_q;
	assign tunnel_binding = tunnel_index_q;

endmodule

`default_nettype wire

// ===== sim/tb_network_bootstrap_sequencer.sv =====
`default_nettype none

module tb_network_bootstrap_sequencer;
	timeunit 1ns;
	timeprecision 1ps;

	import nbs_pkg::*;

	// Event codes that the sequencer must ignore.
	localparam logic [2:0] OP_RESERVED_5 = 3'd5;
	localparam logic [2:0] OP_RESERVED_6 = 3'd6;
	localparam logic [2:0] OP_RESERVED_7 = 3'd7;

	typedef struct packed {
		action_t              act;
		logic                 rearm;
		logic                 stop;
		logic [DELAY_W-1:0]   delay;
		logic [3:0]           phase;
		logic                 tun_en;
		logic [1:0]           tun_idx;
	} link_result_t;

	typedef struct packed {
		logic [2:0]   op;
		logic         v4;
		logic         gw;
		logic [1:0]   gw_idx;
		logic         v6;
		logic         fixed;
		link_result_t res;
	} event_row_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_RANDOM,
		STALL_PERIODIC,
		STALL_HEAVY
	} stall_mode_t;

	localparam link_result_t NO_RES = '0;
	localparam int unsigned N_DIRECTED = 26;
	localparam int unsigned N_PHASES = 6;
	localparam logic [1:0] SEED_PLAN [N_PHASES] = '{2'd3, 2'd1, 2'd0, 2'd2, 2'd3, 2'd0};

	// Directed walk from reset through every phase but renew, the fallback and panic.
	localparam event_row_t DIRECTED_EVENTS [N_DIRECTED] = '{
		'{OP_TICK,       1'b0, 1'b0, 2'd0, 1'b0, 1'b1,
			'{ACT_NONE, 1'b1, 1'b0, DELAY_NOW_MS, PH_OFFLINE, 1'b0, 2'd0}},
		'{OP_TICK,       1'b0, 1'b0, 2'd0, 1'b0, 1'b0, NO_RES},
		'{OP_RESERVED_5, 1'b1, 1'b1, 2'd3, 1'b1, 1'b1,
			'{ACT_NONE, 1'b0, 1'b0, DELAY_NOW_MS, PH_AUTOCONF, 1'b0, 2'd0}},
		'{OP_RESERVED_7, 1'b0, 1'b0, 2'd0, 1'b0, 1'b1,
			'{ACT_NONE, 1'b0, 1'b0, DELAY_NOW_MS, PH_AUTOCONF, 1'b0, 2'd0}},
		'{OP_SHUTDOWN,   1'b1, 1'b1, 2'd3, 1'b1, 1'b1,
			'{ACT_NONE, 1'b0, 1'b1, DELAY_NOW_MS, PH_OFFLINE, 1'b0, 2'd0}},
		'{OP_INITIATE,   1'b1, 1'b1, 2'd3, 1'b1, 1'b1,
			'{ACT_NONE, 1'b1, 1'b0, DELAY_NOW_MS, PH_AUTOCONF, 1'b0, 2'd0}},
		'{OP_TICK,       1'b0, 1'b0, 2'd0, 1'b1, 1'b0, NO_RES},
		'{OP_TICK,       1'b0, 1'b0, 2'd0, 1'b0, 1'b0, NO_RES},
		'{OP_TICK,       1'b1, 1'b1, 2'd2, 1'b1, 1'b0, NO_RES},
		'{OP_TICK,       1'b0, 1'b0, 2'd0, 1'b0, 1'b0, NO_RES},
		'{OP_TICK,       1'b0, 1'b0, 2'd1, 1'b1, 1'b0, NO_RES},
		'{OP_TICK,       1'b1, 1'b0, 2'd0, 1'b1, 1'b0, NO_RES},
		'{OP_TICK,       1'b0, 1'b1, 2'd0, 1'b1, 1'b0, NO_RES},
		'{OP_TICK,       1'b0, 1'b0, 2'd0, 1'b0, 1'b0, NO_RES},
		'{OP_TICK,       1'b1, 1'b0, 2'd0, 1'b0, 1'b0, NO_RES},
		'{OP_TICK,       1'b1, 1'b1, 2'd3, 1'b0, 1'b0, NO_RES},
		'{OP_TICK,       1'b0, 1'b0, 2'd0, 1'b0, 1'b0, NO_RES},
		'{OP_TICK,       1'b1, 1'b1, 2'd0, 1'b1, 1'b0, NO_RES},
		'{OP_RESTART,    1'b0, 1'b0, 2'd0, 1'b0, 1'b0, NO_RES},
		'{OP_SUCCESS,    1'b0, 1'b0, 2'd0, 1'b0, 1'b0, NO_RES},
		'{OP_TICK,       1'b0, 1'b0, 2'd0, 1'b0, 1'b0, NO_RES},
		'{OP_TICK,       1'b1, 1'b1, 2'd1, 1'b1, 1'b0, NO_RES},
		'{OP_TICK,       1'b0, 1'b1, 2'd3, 1'b0, 1'b0, NO_RES},
		'{OP_TICK,       1'b0, 1'b0, 2'd0, 1'b0, 1'b0, NO_RES},
		'{OP_TICK,       1'b1, 1'b0, 2'd2, 1'b1, 1'b0, NO_RES},
		'{OP_RESERVED_6, 1'b1, 1'b1, 2'd3, 1'b1, 1'b0, NO_RES}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [1:0]           cfg_data = 2'd0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [2:0]           operation = 3'd0;
	logic                 have_v4_address = 1'b0;
	logic                 have_gateway_mac = 1'b0;
	logic [1:0]           gateway_binding = 2'd0;
	logic                 have_v6_address = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [2:0]           action;
	logic                 rearm_timer;
	logic                 stop_timer;
	logic [DELAY_W-1:0]   delay_ms;
	logic [3:0]           phase_now;
	logic                 tunnel_enable;
	logic [1:0]           tunnel_binding;

	// Predicted link state and register copy.
	logic [3:0]           lnk_phase;
	logic [RETRY_W-1:0]   lnk_retries;
	logic                 lnk_tun_on;
	logic [1:0]           lnk_tun_idx;
	logic [1:0]           lnk_seed;

	link_result_t         pending_results [$];
	int unsigned          errors = 0;
	int unsigned          burst_left = 0;

	stall_mode_t          stall_mode = STALL_NONE;
	int unsigned          stall_hold = 0;
	int unsigned          stall_cycle = 0;
	logic                 stall_next;

	network_bootstrap_sequencer i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.operation        (operation),
		.have_v4_address  (have_v4_address),
		.have_gateway_mac (have_gateway_mac),
		.gateway_binding  (gateway_binding),
		.have_v6_address  (have_v6_address),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.action           (action),
		.rearm_timer      (rearm_timer),
		.stop_timer       (stop_timer),
		.delay_ms         (delay_ms),
		.phase_now        (phase_now),
		.tunnel_enable    (tunnel_enable),
		.tunnel_binding   (tunnel_binding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Advance the predicted link state by one event and return its result.
	task automatic predict_link_event(input logic [2:0] op, input logic v4, input logic gw_mac,
			input logic [1:0] gw_idx, input logic v6, output link_result_t r);
		logic gw;
		logic [3:0] rule;
		logic done;
		r = '0;
		gw = gw_mac && (int'(gw_idx) < int'(V4_BINDINGS_DEF));
		done = 1'b0;
		case (op)
			OP_TICK: begin
				if (lnk_retries != '0) begin
					lnk_retries = lnk_retries - 1'b1;
				end else begin
					lnk_retries = RETRY_BASE;
					if (lnk_phase <= PH_TUNNEL) begin
						lnk_phase = lnk_phase + 4'd1;
					end else begin
						lnk_phase = PH_PANIC;
					end
				end
				rule = lnk_phase;
				// A present address lets dhcp4 fall through to arp, and a gateway lets
				// arp fall through to tunnel.
				if (rule == PH_DHCP4) begin
					if (!v4) begin
						r.act = ACT_D4DISC;
						r.rearm = 1'b1;
						r.delay = DELAY_LONG_MS;
						lnk_retries = RETRY_SHORT;
						done = 1'b1;
					end else begin
						lnk_phase = PH_ARP;
						lnk_retries = RETRY_BASE;
						rule = PH_ARP;
					end
				end
				if (!done && rule == PH_ARP) begin
					if (!gw) begin
						r.act = ACT_ARPQ;
						r.rearm = 1'b1;
						r.delay = DELAY_ARP_MS;
						done = 1'b1;
					end else begin
						lnk_phase = PH_TUNNEL;
						lnk_retries = RETRY_SHORT;
						rule = PH_TUNNEL;
					end
				end
				// Without an IPv6 address or a gateway the tunnel falls back to dhcp4; otherwise the
				// autoconf rule follows while the phase stays at tunnel.
				if (!done && rule == PH_TUNNEL) begin
					if (!v6) begin
						if (!gw) begin
							lnk_phase = PH_DHCP4;
							lnk_retries = RETRY_SHORT;
							r.rearm = 1'b1;
							r.delay = DELAY_LONG_MS;
							done = 1'b1;
						end else begin
							lnk_tun_on = 1'b1;
							lnk_tun_idx = gw_idx;
						end
					end
					rule = PH_AUTOCONF;
				end
				if (!done) begin
					case (rule)
						PH_AUTOCONF: begin
							if (!v6) begin
								r.act = ACT_RSOL;
								r.rearm = 1'b1;
								r.delay = DELAY_SOL_MS;
							end
						end
						PH_DHCP6: begin
							if (!v6) begin
								r.act = ACT_D6SOL;
								r.rearm = 1'b1;
								r.delay = DELAY_SOL_MS;
							end
						end
						PH_ONLINE, PH_RENEW, PH_PANIC: begin
						end
						default: begin
							r.rearm = 1'b1;
							r.delay = DELAY_NOW_MS;
						end
					endcase
				end
			end
			OP_INITIATE: begin
				lnk_retries = RETRY_BASE + RETRY_W'(lnk_seed);
				lnk_phase = PH_AUTOCONF;
				lnk_tun_on = 1'b0;
				lnk_tun_idx = 2'd0;
				r.rearm = 1'b1;
			end
			OP_SUCCESS: begin
				lnk_phase = PH_ONLINE;
				r.stop = 1'b1;
			end
			OP_RESTART: begin
				lnk_retries = RETRY_BASE + RETRY_W'(lnk_seed);
				lnk_phase = PH_AUTOCONF;
				r.rearm = 1'b1;
			end
			OP_SHUTDOWN: begin
				lnk_retries = RETRY_RESET;
				lnk_phase = PH_OFFLINE;
				lnk_tun_on = 1'b0;
				lnk_tun_idx = 2'd0;
				r.stop = 1'b1;
			end
			default: begin
			end
		endcase
		r.phase = lnk_phase;
		r.tun_en = lnk_tun_on;
		r.tun_idx = lnk_tun_idx;
	endtask

	task automatic check_field(input string name, input int unsigned exp_v,
			input int unsigned act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	task automatic compare_result(input link_result_t exp_r);
		check_field("action", exp_r.act, action);
		check_field("rearm_timer", exp_r.rearm, rearm_timer);
		check_field("stop_timer", exp_r.stop, stop_timer);
		check_field("delay_ms", exp_r.delay, delay_ms);
		check_field("phase_now", exp_r.phase, phase_now);
		check_field("tunnel_enable", exp_r.tun_en, tunnel_enable);
		check_field("tunnel_binding", exp_r.tun_idx, tunnel_binding);
	endtask

	// Present one item in bursts with random gaps, then record its expected result.
	task automatic send_event(input logic [2:0] op, input logic v4, input logic gw,
			input logic [1:0] gw_idx, input logic v6, input logic fixed,
			input link_result_t fixed_res);
		link_result_t predicted;
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
				: $urandom_range(1, 24);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		operation <= op;
		have_v4_address <= v4;
		have_gateway_mac <= gw;
		gateway_binding <= gw_idx;
		have_v6_address <= v6;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		predict_link_event(op, v4, gw, gw_idx, v6, predicted);
		pending_results.push_back(fixed ? fixed_res : predicted);
	endtask

	// Stop sending and let every pending result come out before going idle.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_retry_seed(input logic [1:0] value);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		lnk_seed = value;
		cfg_valid <= 1'b0;
	endtask

	// Most sessions open with initiate or restart and then mostly tick, with per-session
	// odds for the address flags; a few items are random noise.
	task automatic run_random_phase(input int unsigned n_items);
		int unsigned sent;
		int unsigned len;
		int unsigned v4_pct;
		int unsigned gw_pct;
		int unsigned v6_pct;
		int unsigned pick;
		logic [2:0] op;
		sent = 0;
		while (sent < n_items) begin
			v4_pct = $urandom_range(0, 100);
			gw_pct = $urandom_range(0, 100);
			v6_pct = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 100) : $urandom_range(0, 10);
			pick = $urandom_range(0, 9);
			if (pick < 9) begin
				send_event((pick < 6) ? OP_INITIATE : OP_RESTART, 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
					1'($urandom_range(0, 1)), 1'b0, NO_RES);
				sent++;
			end
			len = $urandom_range(4, 48);
			for (int i = 0; i < len; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 8) begin
					send_event(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
						1'($urandom_range(0, 1)), 1'b0, NO_RES);
				end else begin
					if (pick < 95) begin
						op = OP_TICK;
					end else if (pick < 97) begin
						op = OP_SUCCESS;
					end else if (pick < 99) begin
						op = OP_SHUTDOWN;
					end else begin
						op = OP_RESTART;
					end
					send_event(op, $urandom_range(0, 99) < v4_pct, $urandom_range(0, 99) < gw_pct,
						2'($urandom_range(0, 3)), $urandom_range(0, 99) < v6_pct, 1'b0, NO_RES);
				end
				sent++;
			end
		end
	endtask

	// Result side: check each accepted item and pick the next stall.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with no item pending, expected none, actual action %0d phase %0d",
					$time, action, phase_now);
				errors++;
			end else begin
				compare_result(pending_results.pop_front());
			end
		end
		if (stall_hold == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_hold = $urandom_range(32, 200);
		end
		stall_hold--;
		stall_cycle++;
		case (stall_mode)
			STALL_NONE:     stall_next = 1'b0;
			STALL_RANDOM:   stall_next = ($urandom_range(0, 2) == 0);
			STALL_PERIODIC: stall_next = ((stall_cycle % 5) < 2);
			default:        stall_next = ($urandom_range(0, 9) < 8);
		endcase
		out_stall <= stall_next;
	end

	// Directed table first, then random phases under a range of retry seeds.
	initial begin
		lnk_phase = PH_OFFLINE;
		lnk_retries = RETRY_RESET;
		lnk_tun_on = 1'b0;
		lnk_tun_idx = 2'd0;
		lnk_seed = 2'd0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		for (int row = 0; row < N_DIRECTED; row++) begin
			send_event(DIRECTED_EVENTS[row].op, DIRECTED_EVENTS[row].v4, DIRECTED_EVENTS[row].gw,
				DIRECTED_EVENTS[row].gw_idx, DIRECTED_EVENTS[row].v6,
				DIRECTED_EVENTS[row].fixed, DIRECTED_EVENTS[row].res);
		end
		for (int p = 0; p < N_PHASES; p++) begin
			drain_results();
			write_retry_seed(SEED_PLAN[p]);
			run_random_phase(225);
		end
		drain_results();
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("%0t: timeout with %0d results pending", $time, pending_results.size());
		$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire
